// File: hdl/huffman_tree_load_and_decode_unit_defines.svh
// Assertion macros used by the decoder's top module.
`ifndef HUFFMAN_TREE_LOAD_AND_DECODE_UNIT_DEFINES_SVH
`define HUFFMAN_TREE_LOAD_AND_DECODE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define HTD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HTD_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HTD_ASSERT(label, clk, rst_n, prop, msg)
`define HTD_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: hdl/htd_pkg.sv
package htd_pkg;

  localparam int unsigned NodeSlotsDefault  = 512;
  localparam int unsigned StackSlotsDefault = 256;

  localparam logic [1:0] OpDesc = 2'd0;
  localparam logic [1:0] OpData = 2'd1;
  localparam logic [1:0] OpEnd  = 2'd2;

  localparam logic [2:0] KindSymbol     = 3'd0;
  localparam logic [2:0] KindLoaded     = 3'd1;
  localparam logic [2:0] KindTreeErr    = 3'd2;
  localparam logic [2:0] KindComplete   = 3'd3;
  localparam logic [2:0] KindIncomplete = 3'd4;

  localparam logic [7:0] TokLeaf = 8'h31;
  localparam logic [7:0] TokJoin = 8'h30;

  typedef enum logic [2:0] {
    PhToken,
    PhLiteral,
    PhDecode,
    PhDone,
    PhFail
  } phase_e;

  typedef enum logic [3:0] {
    StIdle,
    StPop1,
    StPop2,
    StJoinWr,
    StLoaded,
    StBitRd,
    StBitEval,
    StSend,
    StFlush,
    StSendDone
  } ctrl_e;

endpackage

// File: hdl/htd_node_mem.sv
// Node table: one write port, one registered read port.
module htd_node_mem #(
  parameter int unsigned NodeSlots = htd_pkg::NodeSlotsDefault,
  parameter int unsigned DataW = 19,
  localparam int unsigned AddrW = $clog2(NodeSlots)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [NodeSlots];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/htd_stack_mem.sv
// Build stack: one write port, one registered read port.
module htd_stack_mem #(
  parameter int unsigned StackSlots = htd_pkg::StackSlotsDefault,
  parameter int unsigned DataW = 9,
  localparam int unsigned AddrW = $clog2(StackSlots)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [StackSlots];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/huffman_tree_load_and_decode_unit.sv
// Huffman tree loader and decoder. A leaf token or literal is handled in the
// idle state; a join makes two reads of the build stack, then the node write.
// The join that completes the tree waits until the output register is free
// for its result, and then waits until its result is taken; with a zero symbol
// count the complete result follows. A coded data byte is accepted, then each
// bit takes two dependent node-table reads (the walk node, then the child it
// steps to), each symbol found is sent, and at the end of the byte the held
// symbol is handed out; a byte ends early when the symbol count runs out. Each
// symbol is held back one step until it is known whether another result of
// the same byte follows, so that the final one carries last. Results leave
// through one output register; the block takes one item at a time.
`include "huffman_tree_load_and_decode_unit_defines.svh"
module huffman_tree_load_and_decode_unit #(
  parameter int unsigned NODE_SLOTS  = htd_pkg::NodeSlotsDefault,
  parameter int unsigned STACK_SLOTS = htd_pkg::StackSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  symbol_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned NW = $clog2(NODE_SLOTS);
  localparam int unsigned SW = $clog2(STACK_SLOTS);
  localparam int unsigned PayW = (2 * NW > 8) ? 2 * NW : 8;
  localparam int unsigned EW = PayW + 1;

  // Node entry layout: leaf flag on top, then either the symbol in the low
  // byte (leaf) or the left and right child indices (joined node).
  logic        n_leaf;
  logic [7:0]  n_sym;
  logic [NW-1:0] n_left, n_right;
  logic [EW-1:0] node_rd, node_wd;
  logic        node_we;
  logic [NW-1:0] node_wa, node_ra;
  logic [NW-1:0] stk_rd, stk_wd;
  logic        stk_we;
  logic [SW-1:0] stk_wa, stk_ra;

  htd_pkg::phase_e phase_q, phase_d;
  htd_pkg::ctrl_e  st_q, st_d;
  logic [SW:0]   depth_q, depth_d;
  logic [NW:0]   used_q, used_d;
  logic [NW-1:0] root_q, root_d, walk_q, walk_d, left_q, left_d;
  logic [31:0]   left_cnt_q, left_cnt_d, count_q;
  logic [7:0]    byte_q, byte_d;
  logic [2:0]    bit_q, bit_d;
  logic          pv_q, pv_d;
  logic [7:0]    ps_q, ps_d;
  logic          ov_q, ov_d, ol_q, ol_d;
  logic [2:0]    ok_q, ok_d;
  logic [7:0]    os_q, os_d;

  assign n_leaf  = node_rd[PayW];
  assign n_sym   = node_rd[7:0];
  assign n_left  = node_rd[2*NW-1:NW];
  assign n_right = node_rd[NW-1:0];

  htd_node_mem #(.NodeSlots(NODE_SLOTS), .DataW(EW)) u_node (
    .clk_i, .we_i(node_we), .waddr_i(node_wa), .wdata_i(node_wd),
    .raddr_i(node_ra), .rdata_o(node_rd)
  );

  htd_stack_mem #(.StackSlots(STACK_SLOTS), .DataW(NW)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(stk_ra), .rdata_o(stk_rd)
  );

  assign in_stall_o  = (st_q != htd_pkg::StIdle) || ov_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q;
  assign kind_o      = ok_q;
  assign symbol_o    = os_q;
  assign last_o      = ol_q;

  logic acc;
  assign acc = in_valid_i && !in_stall_o;
  logic out_free;
  assign out_free = !ov_q || !out_stall_i;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      htd_pkg::StIdle: begin
        if (acc) begin
          if (op_i == htd_pkg::OpDesc &&
              (phase_q == htd_pkg::PhToken) && data_byte_i == htd_pkg::TokJoin &&
              depth_q != '0) begin
            st_d = htd_pkg::StPop1;
          end else if (op_i == htd_pkg::OpData && phase_q == htd_pkg::PhDecode) begin
            st_d = htd_pkg::StBitRd;
          end
        end
      end
      htd_pkg::StPop1:   st_d = htd_pkg::StPop2;
      htd_pkg::StPop2:   st_d = (depth_q == (SW+1)'(1)) ? htd_pkg::StLoaded
                                                       : htd_pkg::StJoinWr;
      htd_pkg::StJoinWr: st_d = htd_pkg::StIdle;
      htd_pkg::StLoaded: if (out_free) st_d = (count_q == '0) ? htd_pkg::StSendDone
                                                               : htd_pkg::StIdle;
      htd_pkg::StBitRd:  st_d = n_leaf ? htd_pkg::StSend : htd_pkg::StBitEval;
      htd_pkg::StBitEval: begin
        if (n_leaf) st_d = htd_pkg::StSend;
        else if (bit_q == '0) st_d = htd_pkg::StFlush;
        else st_d = htd_pkg::StBitRd;
      end
      htd_pkg::StSend: begin
        if (!pv_q || out_free) begin
          if (left_cnt_q == 32'd1) st_d = htd_pkg::StSendDone;
          else if (bit_q == '0) st_d = htd_pkg::StFlush;
          else st_d = htd_pkg::StBitRd;
        end
      end
      htd_pkg::StFlush:    if (!pv_q || out_free) st_d = htd_pkg::StIdle;
      htd_pkg::StSendDone: if (out_free && !pv_q) st_d = htd_pkg::StIdle;
      default: st_d = htd_pkg::StIdle;
    endcase
  end

  // Datapath and outputs.
  logic cur_bit;
  assign cur_bit = byte_q[bit_q];

  always_comb begin
    phase_d = phase_q; depth_d = depth_q; used_d = used_q; root_d = root_q;
    walk_d = walk_q; left_d = left_q; left_cnt_d = left_cnt_q; byte_d = byte_q;
    bit_d = bit_q; pv_d = pv_q; ps_d = ps_q;
    ov_d = ov_q && out_stall_i; ok_d = ok_q; os_d = os_q; ol_d = ol_q;
    node_we = 1'b0; node_wa = used_q[NW-1:0]; node_wd = '0;
    node_ra = walk_q;
    stk_we = 1'b0; stk_wa = depth_q[SW-1:0]; stk_wd = used_q[NW-1:0];
    stk_ra = SW'(depth_q - (SW+1)'(1));
    case (st_q)
      htd_pkg::StIdle: begin
        if (acc) begin
          ok_d = htd_pkg::KindTreeErr; os_d = '0; ol_d = 1'b1;
          if (op_i == htd_pkg::OpDesc && phase_q == htd_pkg::PhLiteral) begin
            if (used_q >= (NW+1)'(NODE_SLOTS) || depth_q >= (SW+1)'(STACK_SLOTS)) begin
              ov_d = 1'b1; phase_d = htd_pkg::PhFail;
            end else begin
              node_we = 1'b1;
              node_wd = {1'b1, PayW'(data_byte_i)};
              stk_we = 1'b1;
              depth_d = depth_q + (SW+1)'(1); used_d = used_q + (NW+1)'(1);
              phase_d = htd_pkg::PhToken;
            end
          end else if (op_i == htd_pkg::OpDesc && phase_q == htd_pkg::PhToken) begin
            if (data_byte_i == htd_pkg::TokLeaf) begin
              phase_d = htd_pkg::PhLiteral;
            end else if (data_byte_i != htd_pkg::TokJoin || depth_q == '0) begin
              ov_d = 1'b1; phase_d = htd_pkg::PhFail;
            end
          end else if (op_i == htd_pkg::OpEnd) begin
            if (phase_q == htd_pkg::PhToken || phase_q == htd_pkg::PhLiteral) begin
              ov_d = 1'b1; phase_d = htd_pkg::PhFail;
            end else if (phase_q == htd_pkg::PhDecode) begin
              ov_d = 1'b1; phase_d = htd_pkg::PhDone;
              ok_d = (left_cnt_q != '0) ? htd_pkg::KindIncomplete : htd_pkg::KindComplete;
            end
          end else if (op_i == htd_pkg::OpData && phase_q == htd_pkg::PhDecode) begin
            byte_d = data_byte_i; bit_d = 3'd7;
          end
        end
      end
      htd_pkg::StPop1: begin
        left_d = stk_rd;   // top of stack (right child, or root)
        stk_ra = SW'(depth_q - (SW+1)'(2));
      end
      htd_pkg::StPop2: begin
        // Hold the read of the left child for the node write.
        stk_ra = SW'(depth_q - (SW+1)'(2));
      end
      htd_pkg::StJoinWr: begin
        if (used_q >= (NW+1)'(NODE_SLOTS)) begin
          ov_d = 1'b1; ok_d = htd_pkg::KindTreeErr; os_d = '0; ol_d = 1'b1;
          phase_d = htd_pkg::PhFail;
        end else begin
          node_we = 1'b1;
          node_wd = {1'b0, PayW'({stk_rd, left_q})};
          stk_we = 1'b1; stk_wa = SW'(depth_q - (SW+1)'(2));
          depth_d = depth_q - (SW+1)'(1); used_d = used_q + (NW+1)'(1);
        end
      end
      htd_pkg::StLoaded: begin
        node_ra = left_q;
        if (out_free) begin
          root_d = left_q; walk_d = left_q; depth_d = '0;
          left_cnt_d = count_q; phase_d = htd_pkg::PhDecode;
          ov_d = 1'b1; ok_d = htd_pkg::KindLoaded; os_d = '0;
          ol_d = (count_q != '0);
        end
      end
      htd_pkg::StBitRd: begin
        // The walk node is a leaf only for a one-leaf tree; otherwise step.
        if (!n_leaf) begin
          walk_d = cur_bit ? n_right : n_left;
          node_ra = cur_bit ? n_right : n_left;
        end
      end
      htd_pkg::StBitEval: begin
        // A joined node consumes the bit; a leaf is handled in the send state.
        if (!n_leaf) bit_d = bit_q - 3'd1;
      end
      htd_pkg::StSend: begin
        // Pass any held symbol on and hold the one just found.
        if (!pv_q || out_free) begin
          if (pv_q) begin
            ov_d = 1'b1; ok_d = htd_pkg::KindSymbol; os_d = ps_q; ol_d = 1'b0;
          end
          pv_d = 1'b1; ps_d = n_sym;
          left_cnt_d = left_cnt_q - 32'd1; walk_d = root_q; node_ra = root_q;
          if (left_cnt_q == 32'd1) phase_d = htd_pkg::PhDone;
          bit_d = bit_q - 3'd1;
        end
      end
      htd_pkg::StFlush: begin
        // End of the byte: the held symbol is its final result.
        if (pv_q && out_free) begin
          ov_d = 1'b1; ok_d = htd_pkg::KindSymbol; os_d = ps_q; ol_d = 1'b1;
          pv_d = 1'b0;
        end
      end
      htd_pkg::StSendDone: begin
        if (out_free) begin
          if (pv_q) begin
            ov_d = 1'b1; ok_d = htd_pkg::KindSymbol; os_d = ps_q; ol_d = 1'b0;
            pv_d = 1'b0;
          end else begin
            ov_d = 1'b1; ok_d = htd_pkg::KindComplete; os_d = '0; ol_d = 1'b1;
            phase_d = htd_pkg::PhDone;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= htd_pkg::StIdle; phase_q <= htd_pkg::PhToken;
      depth_q <= '0; used_q <= '0; root_q <= '0; walk_q <= '0;
      left_cnt_q <= '0; ov_q <= 1'b0; pv_q <= 1'b0;
    end else begin
      st_q <= st_d; phase_q <= phase_d; depth_q <= depth_d; used_q <= used_d;
      root_q <= root_d; walk_q <= walk_d; left_cnt_q <= left_cnt_d;
      ov_q <= ov_d; pv_q <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q <= left_d; byte_q <= byte_d; bit_q <= bit_d; ps_q <= ps_d;
    ok_q <= ok_d; os_q <= os_d; ol_q <= ol_d;
  end

  `HTD_ASSERT(a_no_take_busy, clk_i, rst_ni, acc |-> st_q == htd_pkg::StIdle, "busy")
  `HTD_ASSERT(a_out_hold, clk_i, rst_ni, (ov_q && out_stall_i) |=> ov_q, "result dropped")
  `HTD_ASSERT(a_depth, clk_i, rst_ni, depth_q <= (SW+1)'(STACK_SLOTS), "stack overrun")

endmodule

// File: bench/tb_huffman_tree_load_and_decode_unit.sv
`timescale 1ns / 1ps

module tb_huffman_tree_load_and_decode_unit;

  localparam int unsigned NodeSlots  = htd_pkg::NodeSlotsDefault;
  localparam int unsigned StackSlots = htd_pkg::StackSlotsDefault;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 40;
  localparam logic [1:0]  OpUnused = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } code_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] sym;
    logic       last;
  } decode_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = htd_pkg::OpDesc;
  logic [7:0]  data_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  symbol_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = 32'd0;

  code_item_t     pending_q[$];
  decode_result_t expected_q[$];

  int unsigned cycle_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned symbol_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // Decoder state kept by the bench.
  bit          tree_leaf[NodeSlots];
  logic [7:0]  tree_sym[NodeSlots];
  logic [8:0]  tree_left[NodeSlots];
  logic [8:0]  tree_right[NodeSlots];
  logic [8:0]  subtree_stk[StackSlots];
  int unsigned stk_depth = 0;
  int unsigned nodes_alloc = 0;
  htd_pkg::phase_e dec_phase = htd_pkg::PhToken;
  logic [8:0]  root_node = '0;
  logic [8:0]  cur_node = '0;
  logic [31:0] syms_remaining = '0;
  logic [31:0] count_reg = '0;

  huffman_tree_load_and_decode_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .symbol_o    (symbol_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_cnt++;
  endtask

  function automatic void add_result(input logic [2:0] kind, input logic [7:0] sym);
    decode_result_t r;
    r.kind = kind;
    r.sym  = sym;
    r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void tree_fail();
    dec_phase = htd_pkg::PhFail;
    add_result(htd_pkg::KindTreeErr, 8'd0);
  endfunction

  // Tree load from one description byte.
  function automatic void load_desc(input logic [7:0] b);
    if (dec_phase == htd_pkg::PhLiteral) begin
      if (nodes_alloc >= NodeSlots || stk_depth >= StackSlots) begin
        tree_fail();
        return;
      end
      tree_leaf[nodes_alloc]  = 1'b1;
      tree_sym[nodes_alloc]   = b;
      tree_left[nodes_alloc]  = '0;
      tree_right[nodes_alloc] = '0;
      subtree_stk[stk_depth]  = nodes_alloc[8:0];
      stk_depth++;
      nodes_alloc++;
      dec_phase = htd_pkg::PhToken;
    end else if (b == htd_pkg::TokLeaf) begin
      dec_phase = htd_pkg::PhLiteral;
    end else if (b != htd_pkg::TokJoin || stk_depth == 0) begin
      tree_fail();
    end else if (stk_depth == 1) begin
      root_node = subtree_stk[0];
      cur_node = root_node;
      stk_depth = 0;
      syms_remaining = count_reg;
      dec_phase = htd_pkg::PhDecode;
      add_result(htd_pkg::KindLoaded, 8'd0);
      if (syms_remaining == 0) begin
        dec_phase = htd_pkg::PhDone;
        add_result(htd_pkg::KindComplete, 8'd0);
      end
    end else if (nodes_alloc >= NodeSlots) begin
      tree_fail();
    end else begin
      tree_leaf[nodes_alloc]  = 1'b0;
      tree_sym[nodes_alloc]   = 8'd0;
      tree_left[nodes_alloc]  = subtree_stk[stk_depth-2];
      tree_right[nodes_alloc] = subtree_stk[stk_depth-1];
      subtree_stk[stk_depth-2] = nodes_alloc[8:0];
      stk_depth--;
      nodes_alloc++;
    end
  endfunction

  // Walk the tree for the eight bits of a coded byte, most significant first.
  function automatic void decode_bits(input logic [7:0] b);
    logic [8:0] nxt;
    for (int i = 7; i >= 0 && dec_phase == htd_pkg::PhDecode; i--) begin
      if (tree_leaf[root_node]) nxt = root_node;
      else if (b[i]) nxt = tree_right[cur_node];
      else nxt = tree_left[cur_node];
      if (tree_leaf[nxt]) begin
        add_result(htd_pkg::KindSymbol, tree_sym[nxt]);
        syms_remaining--;
        cur_node = root_node;
        if (syms_remaining == 0) begin
          dec_phase = htd_pkg::PhDone;
          add_result(htd_pkg::KindComplete, 8'd0);
        end
      end else begin
        cur_node = nxt;
      end
    end
  endfunction

  function automatic void predict_item(input code_item_t it);
    bit loading;
    int unsigned before_n;
    loading = (dec_phase == htd_pkg::PhToken || dec_phase == htd_pkg::PhLiteral);
    before_n = expected_q.size();
    case (it.op)
      htd_pkg::OpDesc: begin
        if (loading) load_desc(it.data);
      end
      htd_pkg::OpData: begin
        if (dec_phase == htd_pkg::PhDecode) decode_bits(it.data);
      end
      htd_pkg::OpEnd: begin
        if (loading) begin
          tree_fail();
        end else if (dec_phase == htd_pkg::PhDecode) begin
          dec_phase = htd_pkg::PhDone;
          add_result((syms_remaining != 0) ? htd_pkg::KindIncomplete
                                           : htd_pkg::KindComplete, 8'd0);
        end
      end
      default: ;
    endcase
    if (expected_q.size() > before_n) expected_q[expected_q.size()-1].last = 1'b1;
  endfunction

  // Sender: one transfer per accepted item, random gaps outside the quiet window.
  always @(posedge clk_i) begin
    code_item_t nxt;
    bit         gap;
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (in_valid_i) begin
        predict_item('{op: op_i, data: data_byte_i});
        accepted_cnt++;
      end
      gap = (cycle_cnt < 3000 || cycle_cnt >= 6000) && ($urandom_range(99) < 10);
      if (pending_q.size() != 0 && !gap) begin
        nxt = pending_q.pop_front();
        in_valid_i  <= 1'b1;
        op_i        <= nxt.op;
        data_byte_i <= nxt.data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: checks each result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    decode_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_cnt++;
      if (kind_o == htd_pkg::KindSymbol) symbol_cnt++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d sym=%02h last=%0b",
                                  kind_o, symbol_o, last_o));
      end else begin
        e = expected_q.pop_front();
        if (kind_o !== e.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", kind_o, e.kind));
        if (symbol_o !== e.sym)
          report_mismatch($sformatf("symbol %02h, expected %02h", symbol_o, e.sym));
        if (last_o !== e.last)
          report_mismatch($sformatf("last %0b, expected %0b", last_o, e.last));
      end
    end
  end

  // Long hold-off once, after a few dozen results, so the block backs up.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && result_cnt >= 40) begin
      hold_done <= 1'b1;
      hold_left <= 400;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= (hold_left > 1) ||
                   ((cycle_cnt < 3000 || cycle_cnt >= 6000) && $urandom_range(99) < 10);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_count(input logic [31:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    count_reg = v;
  endtask

  // Waits until every item is taken and every result has come, then settles.
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic queue_item(input logic [1:0] op, input logic [7:0] b);
    pending_q.push_back('{op: op, data: b});
  endtask

  initial begin
    int unsigned n_leaves;
    int unsigned pushed;
    int unsigned depth;
    logic [7:0]  lit;
    logic [31:0] loaded_cnt;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Count register through its extremes; the last value written is the one loaded.
    write_count(32'd0);
    write_count(32'hFFFF_FFFF);
    if ($urandom_range(1)) write_count(32'hFFFF_FFFF);
    else write_count($urandom_range(1500, 400));

    // Tree description in post-order with noise that the load ignores.
    n_leaves = ($urandom_range(5) == 0) ? 1 : $urandom_range(9, 2);
    pushed = 0;
    depth = 0;
    queue_item(htd_pkg::OpData, 8'hA5);
    queue_item(OpUnused, 8'h5A);
    while (pushed < n_leaves || depth > 1) begin
      if (pushed < n_leaves && (depth < 2 || $urandom_range(1))) begin
        lit = (pushed == 0) ? 8'h00 : (pushed == 1) ? 8'hFF : 8'($urandom);
        queue_item(htd_pkg::OpDesc, htd_pkg::TokLeaf);
        queue_item(htd_pkg::OpDesc, lit);
        pushed++;
        depth++;
      end else begin
        queue_item(htd_pkg::OpDesc, htd_pkg::TokJoin);
        depth--;
      end
      if ($urandom_range(7) == 0)
        queue_item($urandom_range(1) ? htd_pkg::OpData : OpUnused, 8'($urandom));
    end
    queue_item(htd_pkg::OpDesc, htd_pkg::TokJoin);
    wait_drained();
    loaded_cnt = count_reg;

    // A write after the load must not change the count in use.
    write_count(32'd0);

    // First coded bytes, extremes first; then the sender pauses until all results are in.
    queue_item(htd_pkg::OpData, 8'h00);
    queue_item(htd_pkg::OpData, 8'hFF);
    queue_item(htd_pkg::OpData, 8'h55);
    queue_item(htd_pkg::OpData, 8'hAA);
    for (int i = 0; i < 40; i++) queue_item(htd_pkg::OpData, 8'($urandom));
    wait_drained();

    for (int i = 0; i < 170; i++) begin
      if ($urandom_range(19) == 0)
        queue_item($urandom_range(1) ? htd_pkg::OpDesc : OpUnused, 8'($urandom));
      queue_item(htd_pkg::OpData, 8'($urandom));
    end
    queue_item(htd_pkg::OpEnd, 8'($urandom));
    // Everything after the end is ignored.
    queue_item(htd_pkg::OpData, 8'hFF);
    queue_item(htd_pkg::OpDesc, htd_pkg::TokLeaf);
    queue_item(htd_pkg::OpEnd, 8'h00);
    queue_item(OpUnused, 8'h00);
    wait_drained();
    write_count(32'hFFFF_FFFF);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Loaded a %0d-leaf tree with a symbol count of %0d, then sent %0d items in all.",
             n_leaves, loaded_cnt, accepted_cnt);
    $display("Checked %0d results, %0d of them decoded symbols; %0d mismatches.",
             result_cnt, symbol_cnt, error_cnt);
    if (error_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: huffman_tree_load_and_decode_unit.f
+incdir+hdl
hdl/htd_pkg.sv
hdl/htd_node_mem.sv
hdl/htd_stack_mem.sv
hdl/huffman_tree_load_and_decode_unit.sv
bench/tb_huffman_tree_load_and_decode_unit.sv
